FILE: rtl/assert_macros.svh
// Assertion macros used by the checker module of the block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define MTFR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("move-to-front rank check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define MTFR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("move-to-front rank check failed");

`endif

FILE: rtl/mtfr_pkg.sv
// Shared types and constants of the move-to-front rank encoder.
// No dependencies.
package mtfr_pkg;

    localparam int SYM_W           = 9;
    localparam int POS_W           = 8;
    localparam int MAX_SYMBOLS_DEF = 256;
    localparam logic [SYM_W-1:0] COUNT_RESET = 9'd256;
    localparam logic [POS_W-1:0] POS_SAT     = 8'hFF;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_LOOK = 3'b010,
        ST_MOVE = 3'b100
    } t_state;

    // Per-cell control: reload the initial order, or take the neighbor's entry.
    typedef struct packed {
        logic init;
        logic take;
    } t_cell_ctrl;

endpackage

FILE: rtl/mtfr_cell.sv
// One list slot of the move-to-front chain: holds an entry, flags a match.
// Depends on mtfr_pkg.
module mtfr_cell
    import mtfr_pkg::*;
#(
    parameter int                  ENTRY_W  = 9,
    parameter logic [ENTRY_W-1:0]  INIT_VAL = '0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cell_ctrl         i_ctrl,
    input  logic [ENTRY_W-1:0] i_prev,
    input  logic [ENTRY_W-1:0] i_sym,
    output logic [ENTRY_W-1:0] o_entry,
    output logic               o_hit
);

    logic [ENTRY_W-1:0] r_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.init) begin
            r_entry <= INIT_VAL;
        end else if (i_ctrl.take) begin
            r_entry <= i_prev;
        end
    end

    assign o_entry = r_entry;
    assign o_hit   = (r_entry == i_sym);

endmodule

FILE: rtl/mtfr_encode.sv
// Turns the chain's match flags into the index of the matching slot.
// No package dependencies; at most one flag is expected high.
module mtfr_encode #(
    parameter int N     = 256,
    parameter int IDX_W = 8
) (
    input  logic [N-1:0]     i_hits,
    output logic [IDX_W-1:0] o_idx
);

    always_comb begin
        o_idx = '0;
        for (int i = 0; i < N; i++) begin
            if (i_hits[i]) begin
                o_idx = o_idx | IDX_W'(i);
            end
        end
    end

endmodule

FILE: rtl/move_to_front_rank_top.sv
// Move-to-front rank encoder: top level with control, chain of cells and encoder.
// Depends on mtfr_pkg, mtfr_cell and mtfr_encode.
//
// Use: the input channel (i_in_valid / o_in_stall) carries one symbol per
// request; the output channel (o_out_valid / i_out_stall) returns its rank,
// the number of list entries ahead of it, and a bad-symbol flag for symbols
// outside 1..min(count, MAX_SYMBOLS). The configuration channel (i_cfg_valid /
// o_cfg_ready) writes the symbol count and restores the list to 1,2,...,MAX_SYMBOLS.
// Each list slot is a cell; all cells compare against the symbol at once,
// then the slots ahead of the match shift back one place in the shift state.
// The result is registered in the compare state once the output register is
// free. A new request is taken during the shift state of the cell chain,
// but not during the compare state.
// Reset (synchronous, active low) loads the order 1..MAX_SYMBOLS into the
// cells at once and sets the count to 256; no clearing pass is needed.
// A stalled result is held in the output register; the compare cycle waits
// until that register frees, so no result is dropped.
module move_to_front_rank_top
    import mtfr_pkg::*;
#(
    parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [SYM_W-1:0] i_symbol,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [POS_W-1:0] o_position,
    output logic             o_bad_symbol,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [SYM_W-1:0] i_cfg_symbol_count
);

    localparam int ENTRY_W = $clog2(MAX_SYMBOLS + 1);
    localparam int IDX_W   = $clog2(MAX_SYMBOLS);
    localparam int CMP_W   = (ENTRY_W > SYM_W) ? ENTRY_W : SYM_W;
    localparam int SAT_W   = (IDX_W > POS_W) ? IDX_W : POS_W;

    t_state             r_state, n_state;
    logic [SYM_W-1:0]   r_sym;
    logic [SYM_W-1:0]   r_count;
    logic [IDX_W-1:0]   r_idx;
    logic               r_move;
    logic               r_out_valid;
    logic [POS_W-1:0]   r_out_pos;
    logic               r_out_bad;

    logic               accept_in;
    logic               cfg_wr;
    logic               out_free;
    logic               do_look;
    logic               sym_ok;
    logic [POS_W-1:0]   pos_sat;
    logic [SAT_W-1:0]   idx_ext;
    logic [IDX_W-1:0]   hit_idx;
    logic [ENTRY_W-1:0] sym_entry;
    logic [MAX_SYMBOLS-1:0]        hits;
    logic [ENTRY_W-1:0]            entries [MAX_SYMBOLS];
    t_cell_ctrl                    ctrl    [MAX_SYMBOLS];

    assign o_in_stall  = (r_state == ST_LOOK);
    assign o_cfg_ready = (r_state != ST_LOOK);
    assign accept_in   = i_in_valid && !o_in_stall;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign do_look     = (r_state == ST_LOOK) && out_free;
    assign sym_entry   = ENTRY_W'(r_sym);

    // Symbol must lie in 1..min(count, MAX_SYMBOLS).
    assign sym_ok = (r_sym != '0) && (r_sym <= r_count)
                 && (CMP_W'(r_sym) <= CMP_W'(MAX_SYMBOLS));

    assign idx_ext = SAT_W'(hit_idx);
    assign pos_sat = (idx_ext > SAT_W'(POS_SAT)) ? POS_SAT : idx_ext[POS_W-1:0];

    // Chain of cells: slot i takes slot i-1's entry, slot 0 takes the symbol.
    for (genvar i = 0; i < MAX_SYMBOLS; i++) begin : g_cell
        assign ctrl[i].init = cfg_wr;
        assign ctrl[i].take = (r_state == ST_MOVE) && r_move && (IDX_W'(i) <= r_idx);

        mtfr_cell #(
            .ENTRY_W  (ENTRY_W),
            .INIT_VAL (ENTRY_W'(i + 1))
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (ctrl[i]),
            .i_prev  ((i == 0) ? sym_entry : entries[(i == 0) ? 0 : i - 1]),
            .i_sym   (sym_entry),
            .o_entry (entries[i]),
            .o_hit   (hits[i])
        );
    end

    mtfr_encode #(
        .N     (MAX_SYMBOLS),
        .IDX_W (IDX_W)
    ) u_encode (
        .i_hits (hits),
        .o_idx  (hit_idx)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept_in) n_state = ST_LOOK;
            end
            ST_LOOK: begin
                if (out_free) n_state = ST_MOVE;
            end
            ST_MOVE: begin
                n_state = accept_in ? ST_LOOK : ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= COUNT_RESET;
            r_move      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_wr) begin
                r_count <= i_cfg_symbol_count;
            end
            if (do_look) begin
                r_move      <= sym_ok;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: no reset.
    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_sym <= i_symbol;
        end
        if (do_look) begin
            r_idx     <= hit_idx;
            r_out_pos <= sym_ok ? pos_sat : '0;
            r_out_bad <= !sym_ok;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_position   = r_out_pos;
    assign o_bad_symbol = r_out_bad;

endmodule

FILE: rtl/mtfr_checker.sv
// Port-level checks of the move-to-front rank encoder, bound to its top level.
// Depends on mtfr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mtfr_checker
    import mtfr_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_stall,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input logic [POS_W-1:0] o_position,
    input logic             o_bad_symbol
);

    // A stalled result holds.
    `MTFR_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_position) && $stable(o_bad_symbol))

    // A bad symbol reports rank zero.
    `MTFR_ASSERT_IMP(a_bad_pos, i_clk, i_rst_n, o_out_valid && o_bad_symbol,
        o_position == '0)

    // One request at a time: the compare cycle follows every accepted request.
    `MTFR_ASSERT_NXT(a_one_item, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

    // A new result only comes out of a compare cycle.
    `MTFR_ASSERT_IMP(a_out_source, i_clk, i_rst_n, $rose(o_out_valid), $past(o_in_stall))

endmodule

bind move_to_front_rank_top mtfr_checker u_mtfr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_position   (o_position),
    .o_bad_symbol (o_bad_symbol)
);

FILE: verif/move_to_front_rank_top_tb.sv
// Self-checking bench for the move-to-front rank encoder: directed and random symbols,
// random sender gaps and receiver stalls, several symbol counts including the extremes.
// Depends on mtfr_pkg and move_to_front_rank_top.
module move_to_front_rank_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mtfr_pkg::*;

    localparam int IDLE_LIMIT = 2000;

    // Tracks the symbol list and holds the ranks still owed by the block.
    class rank_scoreboard;
        typedef struct {
            logic [POS_W-1:0] position;
            logic             bad_symbol;
        } t_rank;

        logic [SYM_W-1:0] order[MAX_SYMBOLS_DEF];
        int unsigned      count;
        t_rank            ranks_due[$];
        int               errors;

        function new();
            errors = 0;
            set_count(COUNT_RESET);
        endfunction

        function void set_count(logic [SYM_W-1:0] value);
            count = value;
            for (int i = 0; i < MAX_SYMBOLS_DEF; i++) begin
                order[i] = SYM_W'(i + 1);
            end
        endfunction

        function int active();
            return (count > MAX_SYMBOLS_DEF) ? MAX_SYMBOLS_DEF : int'(count);
        endfunction

        function int pending();
            return ranks_due.size();
        endfunction

        function void note_symbol(logic [SYM_W-1:0] sym);
            int    n;
            int    p;
            t_rank r;
            n = active();
            p = -1;
            if (sym >= 1 && sym <= n) begin
                for (int i = 0; i < n; i++) begin
                    if (order[i] == sym) begin
                        p = i;
                        break;
                    end
                end
            end
            if (p < 0) begin
                // out of range: flag it and leave the list alone
                r.position   = '0;
                r.bad_symbol = 1'b1;
            end else begin
                r.position   = (p > 255) ? POS_SAT : POS_W'(p);
                r.bad_symbol = 1'b0;
                for (int i = p; i > 0; i--) begin
                    order[i] = order[i-1];
                end
                order[0] = sym;
            end
            ranks_due.push_back(r);
        endfunction

        function void check_result(logic [POS_W-1:0] position, logic bad_symbol);
            t_rank r;
            if (ranks_due.size() == 0) begin
                $error("rank with none due: position=%0d bad_symbol=%0b",
                       position, bad_symbol);
                errors++;
                return;
            end
            r = ranks_due.pop_front();
            if (position !== r.position) begin
                $error("position: expected %0d, got %0d", r.position, position);
                errors++;
            end
            if (bad_symbol !== r.bad_symbol) begin
                $error("bad_symbol: expected %0b, got %0b", r.bad_symbol, bad_symbol);
                errors++;
            end
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_stall;
    logic [SYM_W-1:0] i_symbol;
    logic             o_out_valid;
    logic             i_out_stall;
    logic [POS_W-1:0] o_position;
    logic             o_bad_symbol;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [SYM_W-1:0] i_cfg_symbol_count;

    rank_scoreboard sb;
    int             idle_cycles;

    move_to_front_rank_top dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_symbol           (i_symbol),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_position         (o_position),
        .o_bad_symbol       (o_bad_symbol),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_symbol_count (i_cfg_symbol_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver stalls: short bursts between free runs, now and then a long stall or a long free run.
    initial begin
        int r;
        forever begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end else if (r < 55) begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(30, 80)) @(posedge i_clk);
            end else if (r < 88) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end else if (r < 97) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(4, 12)) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(20, 60)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_position, o_bad_symbol);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("[move_to_front_rank_top] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Mostly legal symbols, biased toward the front of the list; a few out of range.
    function automatic logic [SYM_W-1:0] pick_symbol();
        int n;
        int r;
        n = sb.active();
        r = $urandom_range(0, 99);
        if (n == 0 || r < 10) begin
            if ($urandom_range(0, 3) == 0) return '0;
            return SYM_W'($urandom_range(n + 1, 511));
        end
        if (r < 45) return sb.order[$urandom_range(0, (n < 8) ? n - 1 : 7)];
        return SYM_W'($urandom_range(1, n));
    endfunction

    task automatic send_symbol(logic [SYM_W-1:0] sym, int gap);
        i_symbol   <= sym;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_symbol(sym);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_count(logic [SYM_W-1:0] value);
        wait_drained();
        repeat (3) @(posedge i_clk);
        i_cfg_symbol_count <= value;
        i_cfg_valid        <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.set_count(value);
    endtask

    initial begin
        logic [SYM_W-1:0] phase_counts[7];
        bit               quiet;

        sb                 = new();
        idle_cycles        = 0;
        i_rst_n            <= 1'b0;
        i_in_valid         <= 1'b0;
        i_symbol           <= '0;
        i_cfg_valid        <= 1'b0;
        i_cfg_symbol_count <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset order, full count: front, back, repeat, zero and out-of-range symbols.
        foreach (phase_counts[i]) phase_counts[i] = '0;
        send_symbol(9'd1, sender_gap());
        send_symbol(9'd256, sender_gap());
        send_symbol(9'd256, sender_gap());
        send_symbol(9'd255, sender_gap());
        send_symbol(9'd0, sender_gap());
        send_symbol(9'd511, sender_gap());
        send_symbol(9'd257, sender_gap());
        send_symbol(9'd128, sender_gap());
        send_symbol(9'd2, sender_gap());

        // Single-symbol list.
        write_count(9'd1);
        send_symbol(9'd1, sender_gap());
        send_symbol(9'd1, sender_gap());
        send_symbol(9'd2, sender_gap());
        send_symbol(9'd0, sender_gap());

        // Empty list: everything is bad.
        write_count(9'd0);
        send_symbol(9'd1, sender_gap());
        send_symbol(9'd0, sender_gap());
        send_symbol(9'd256, sender_gap());

        // Count above the list size saturates.
        write_count(9'd511);
        send_symbol(9'd256, sender_gap());
        send_symbol(9'd1, sender_gap());
        send_symbol(9'd256, sender_gap());
        send_symbol(9'd257, sender_gap());

        write_count(9'd257);
        send_symbol(9'd256, sender_gap());
        send_symbol(9'd257, sender_gap());

        write_count(9'd3);
        send_symbol(9'd3, sender_gap());
        send_symbol(9'd2, sender_gap());
        send_symbol(9'd3, sender_gap());

        phase_counts = '{9'd256, 9'd2, 9'd37, 9'd511, 9'd100, 9'd256,
                         SYM_W'($urandom_range(1, 256))};
        foreach (phase_counts[ph]) begin
            write_count(phase_counts[ph]);
            quiet = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < 54; k++) begin
                // hold off the sender once until the block has caught up
                if (ph == 2 && k == 27) wait_drained();
                send_symbol(pick_symbol(), quiet ? 0 : sender_gap());
            end
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("[move_to_front_rank_top] OK");
        end else begin
            $display("[move_to_front_rank_top] ERROR");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/mtfr_pkg.sv
rtl/mtfr_cell.sv
rtl/mtfr_encode.sv
rtl/move_to_front_rank_top.sv
rtl/mtfr_checker.sv
verif/move_to_front_rank_top_tb.sv
